FILE: sv/stfi_pkg.sv
// Shared types and constants for the sorted table find-or-insert block.
`timescale 1ns / 1ps

package stfi_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 128;
    localparam int KEY_W               = 32;
    localparam int OUTCOME_W           = 2;
    localparam int POS_W               = 7;
    localparam int COUNT_W             = 8;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_SWAPPED  = 2'd0,
        OUT_AT_LAST  = 2'd1,
        OUT_INSERTED = 2'd2,
        OUT_FULL     = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_SWAP,
        CELL_INSERT
    } t_cell_op;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cell_rsp;

endpackage

FILE: sv/sorted_table_find_or_insert.sv
// Top level of the sorted table find-or-insert block: search control and cell row.
//
// Keeps an ascending table of signed 32-bit keys in a row of TABLE_DEPTH cells.
// Input channel: i_in_valid / o_in_stall with i_key. Each request is looked up
// by binary search; a hit that is not the last entry swaps with its successor,
// a miss is inserted at its sorted place (later entries move up one cell), and
// a miss on a full table is dropped with outcome full.
// Output channel: o_out_valid / i_out_stall with o_outcome, o_position and
// o_entry_count, exactly one result per request.
// Sequence: after acceptance, all cells compare against the key; the search then
// probes the table (up to clog2(TABLE_DEPTH+1) probes, 8 at depth 128), a search
// that misses takes one more step to close, and a last step updates the row and
// loads the result register. One request is in flight at a time.
// A finished result waits in the output register; the next request is accepted
// meanwhile, but its update waits until the held result is taken.
// Reset empties the table (entry count zero) and clears the output valid; the
// cell contents themselves are not cleared.
`timescale 1ns / 1ps

module sorted_table_find_or_insert
    import stfi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [OUTCOME_W-1:0]    o_outcome,
    output logic [POS_W-1:0]        o_position,
    output logic [COUNT_W-1:0]      o_entry_count
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SRCH,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic                    r_found;
    logic [IW-1:0]           r_pos;
    logic [CW-1:0]           r_count;
    logic                    r_out_valid;
    t_outcome                r_outcome;
    logic [POS_W-1:0]        r_position;
    logic [COUNT_W-1:0]      r_entry_count;

    logic [CW:0]             w_sum;
    logic [IW-1:0]           w_mid;
    logic                    w_commit;
    logic                    w_swap;
    logic                    w_insert;
    logic [IW-1:0]           w_pos;
    logic [CW-1:0]           n_count;
    t_cell_op                w_op;
    t_cell_rsp               w_rsp;

    logic signed [KEY_W-1:0] w_cell_key [TABLE_DEPTH];
    t_cell_rsp               w_cell_rsp [TABLE_DEPTH];

    assign w_sum    = (CW+1)'(r_lo) + (CW+1)'(r_hi) - (CW+1)'(1);
    assign w_mid    = w_sum[IW:1];
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_swap   = r_found && ((CW'(r_pos) + CW'(1)) < r_count);
    assign w_insert = !r_found && (r_count < CW'(TABLE_DEPTH));
    assign w_pos    = r_found ? r_pos : r_lo[IW-1:0];
    assign n_count  = w_insert ? r_count + CW'(1) : r_count;

    always_comb begin
        w_op = CELL_HOLD;
        if (r_state == S_CMP) begin
            w_op = CELL_CMP;
        end else if (w_commit && w_swap) begin
            w_op = CELL_SWAP;
        end else if (w_commit && w_insert) begin
            w_op = CELL_INSERT;
        end
    end

    always_comb begin
        w_rsp = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_rsp = w_rsp | w_cell_rsp[i];
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic signed [KEY_W-1:0] w_left;
        logic signed [KEY_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_left
            assign w_left = w_cell_key[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_right
            assign w_right = w_cell_key[g+1];
        end

        stfi_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_key       (r_key),
            .i_pos       (w_pos),
            .i_count     (r_count),
            .i_mid       (w_mid),
            .i_left_key  (w_left),
            .i_right_key (w_right),
            .o_key       (w_cell_key[g]),
            .o_rsp       (w_cell_rsp[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_commit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key   <= i_key;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_lo    <= '0;
                    r_hi    <= r_count;
                    r_found <= 1'b0;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        if (w_rsp.eq) begin
                            r_found <= 1'b1;
                            r_pos   <= w_mid;
                            r_state <= S_DONE;
                        end else if (w_rsp.lt) begin
                            r_hi <= CW'(w_mid);
                        end else begin
                            r_lo <= CW'(w_mid) + CW'(1);
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_commit) begin
                        r_out_valid   <= 1'b1;
                        r_count       <= n_count;
                        r_entry_count <= COUNT_W'(n_count);
                        if (r_found) begin
                            r_outcome  <= w_swap ? OUT_SWAPPED : OUT_AT_LAST;
                            r_position <= POS_W'(r_pos);
                        end else if (w_insert) begin
                            r_outcome  <= OUT_INSERTED;
                            r_position <= POS_W'(r_lo);
                        end else begin
                            r_outcome  <= OUT_FULL;
                            r_position <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;

endmodule

FILE: sv/stfi_cell.sv
// One table cell: holds a key, compares it, and shifts or swaps with its neighbors.
`timescale 1ns / 1ps

module stfi_cell
    import stfi_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 7,
    parameter int CW  = 8
) (
    input  logic                    i_clk,
    input  t_cell_op                i_op,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [IW-1:0]           i_pos,
    input  logic [CW-1:0]           i_count,
    input  logic [IW-1:0]           i_mid,
    input  logic signed [KEY_W-1:0] i_left_key,
    input  logic signed [KEY_W-1:0] i_right_key,
    output logic signed [KEY_W-1:0] o_key,
    output t_cell_rsp               o_rsp
);

    localparam logic [CW:0]   ME     = (CW+1)'(IDX);
    localparam logic [IW-1:0] ME_IDX = IW'(IDX);

    logic signed [KEY_W-1:0] r_val;
    logic                    r_eq;
    logic                    r_lt;
    logic [CW:0]             w_pos;
    logic [CW:0]             w_cnt;

    assign w_pos = (CW+1)'(i_pos);
    assign w_cnt = (CW+1)'(i_count);

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_CMP: begin
                r_eq <= (r_val == i_key);
                r_lt <= (i_key < r_val);
            end
            CELL_SWAP: begin
                if (ME == w_pos) begin
                    r_val <= i_right_key;
                end else if (ME == w_pos + (CW+1)'(1)) begin
                    r_val <= i_left_key;
                end
            end
            CELL_INSERT: begin
                if (ME == w_pos) begin
                    r_val <= i_key;
                end else if (ME > w_pos && ME <= w_cnt) begin
                    r_val <= i_left_key;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key  = r_val;
    assign o_rsp.eq = r_eq & (i_mid == ME_IDX);
    assign o_rsp.lt = r_lt & (i_mid == ME_IDX);

endmodule

FILE: sv/stfi_chk.sv
// Port-level checker for the sorted table find-or-insert block, with its bind.
`timescale 1ns / 1ps

module stfi_chk
    import stfi_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic signed [KEY_W-1:0] i_key,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [OUTCOME_W-1:0]    o_outcome,
    input logic [POS_W-1:0]        o_position,
    input logic [COUNT_W-1:0]      o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_outcome)
            && $stable(o_position) && $stable(o_entry_count))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted on back-to-back cycles");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no request in progress");

    a_full_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OUT_FULL) |-> (o_position == '0))
        else $error("dropped insert reports a nonzero position");

endmodule

bind sorted_table_find_or_insert stfi_chk u_stfi_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_key         (i_key),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_outcome     (o_outcome),
    .o_position    (o_position),
    .o_entry_count (o_entry_count)
);
